// ===== rtl/two_road_priority_traffic_light_unit_macros.svh =====
// ---------------------------------------------------------------------------
// two road priority traffic light unit assertion macros
// shared property shapes for the checker
// ---------------------------------------------------------------------------
`ifndef TWO_ROAD_PRIORITY_TRAFFIC_LIGHT_UNIT_MACROS_SVH
`define TWO_ROAD_PRIORITY_TRAFFIC_LIGHT_UNIT_MACROS_SVH

// same-cycle implication
`define TRTL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("trtl assertion failed");

// next-cycle implication
`define TRTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("trtl assertion failed");

`endif

// ===== rtl/trtl_pkg.sv =====
// ---------------------------------------------------------------------------
// trtl_pkg
// types, codes and display helpers of the two road traffic light unit
// ---------------------------------------------------------------------------
package trtl_pkg;

  localparam int unsigned DistW   = 10;
  localparam int unsigned GreenW  = 7;
  localparam int unsigned YellowW = 4;
  localparam int unsigned BandW   = 10;
  localparam int unsigned SegW    = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned InW     = 24;
  localparam int unsigned OutW    = 16;

  typedef enum logic [1:0] {
    PH_GREEN1,
    PH_YELLOW1,
    PH_GREEN2,
    PH_YELLOW2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_GREEN,
    CFG_SHORT_GREEN,
    CFG_YELLOW_TICKS,
    CFG_EQUAL_BAND
  } cfg_idx_e;

  localparam logic [1:0] LightRed    = 2'd0;
  localparam logic [1:0] LightGreen  = 2'd1;
  localparam logic [1:0] LightYellow = 2'd2;

  localparam logic [1:0] PrioEqual = 2'd0;
  localparam logic [1:0] PrioA     = 2'd1;
  localparam logic [1:0] PrioB     = 2'd2;

  localparam logic RoadA = 1'b0;
  localparam logic RoadB = 1'b1;

  localparam logic [GreenW-1:0]  LongGreenRst   = 7'd10;
  localparam logic [GreenW-1:0]  ShortGreenRst  = 7'd5;
  localparam logic [YellowW-1:0] YellowTicksRst = 4'd2;
  localparam logic [BandW-1:0]   EqualBandRst   = 10'd5;

  // count mod 10 via reciprocal multiply, exact for 7-bit values
  function automatic logic [3:0] mod10(input logic [GreenW-1:0] x);
    logic [14:0] prod;
    logic [3:0]  quo;
    logic [GreenW-1:0] tens;
    prod = {8'd0, x} * 15'd205;
    quo  = prod[14:11];
    tens = GreenW'({3'd0, quo} * 7'd10);
    return 4'(x - tens);
  endfunction

  // common-cathode pattern, bit0 segment a
  function automatic logic [SegW-1:0] seg_of_digit(input logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/two_road_priority_traffic_light_unit.sv =====
// ---------------------------------------------------------------------------
// two_road_priority_traffic_light_unit
// per-tick sequencer for two roads with distance based priority and
// seven-segment countdown display
// ---------------------------------------------------------------------------
// an accepted tick's result stands in the output register in the next cycle
// throughput: one tick per cycle while the output is not stalled, set by the single state update per transaction
// the output register lets a new tick in while the held result is taken
// reset: asynchronous, registers but the output data to their defaults, phase at first green, idle
// ---------------------------------------------------------------------------
module two_road_priority_traffic_light_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // dist_a [9:0], dist_b [19:10], zero pad [23:20]
  input  logic [trtl_pkg::InW-1:0]          s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // light_a [1:0], light_b [3:2], segments [10:4], priority_code [12:11],
  // go_road [13], zero pad [15:14]
  output logic [trtl_pkg::OutW-1:0]         m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [trtl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [trtl_pkg::CfgW-1:0]         cfg_data_i
);
  import trtl_pkg::*;

  logic [GreenW-1:0]  long_green_q, short_green_q;
  logic [YellowW-1:0] yellow_ticks_q;
  logic [BandW-1:0]   equal_band_q;

  phase_e            phase_q, phase_d;
  logic [GreenW-1:0] tick_count_q, tick_count_d;
  logic              first_road_q, first_road_d;
  logic [GreenW-1:0] second_green_q, second_green_d;
  logic [1:0]        prio_q, prio_d;
  logic              running_q, running_d;

  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q, out_data_d;

  logic [DistW-1:0]  dist_a, dist_b, diff;
  logic              accept;
  phase_e            ph_cur;
  logic [GreenW-1:0] cnt_cur;
  logic              road;
  logic [1:0]        lamp;
  logic [SegW-1:0]   seg;

  assign dist_a = s_axis_tdata[DistW-1:0];
  assign dist_b = s_axis_tdata[2*DistW-1:DistW];
  assign diff   = (dist_a > dist_b) ? (dist_a - dist_b) : (dist_b - dist_a);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // cycle start selection
  always_comb begin
    first_road_d   = first_road_q;
    second_green_d = second_green_q;
    prio_d         = prio_q;
    ph_cur         = phase_q;
    cnt_cur        = tick_count_q;
    if (!running_q) begin
      ph_cur  = PH_GREEN1;
      cnt_cur = long_green_q;
      if (diff < equal_band_q) begin
        prio_d         = PrioEqual;
        first_road_d   = RoadA;
        second_green_d = long_green_q;
      end else if (dist_a < dist_b) begin
        prio_d         = PrioA;
        first_road_d   = RoadA;
        second_green_d = short_green_q;
      end else begin
        prio_d         = PrioB;
        first_road_d   = RoadB;
        second_green_d = short_green_q;
      end
    end
  end

  // next state
  always_comb begin
    phase_d      = ph_cur;
    tick_count_d = cnt_cur;
    running_d    = 1'b1;
    unique case (ph_cur)
      PH_GREEN1, PH_GREEN2: begin
        if (cnt_cur == '0) begin
          phase_d      = (ph_cur == PH_GREEN1) ? PH_YELLOW1 : PH_YELLOW2;
          tick_count_d = {3'd0, yellow_ticks_q};
        end else begin
          tick_count_d = cnt_cur - 1'b1;
        end
      end
      PH_YELLOW1: begin
        if (cnt_cur <= 7'd1) begin
          phase_d      = PH_GREEN2;
          tick_count_d = second_green_d;
        end else begin
          tick_count_d = cnt_cur - 1'b1;
        end
      end
      PH_YELLOW2: begin
        if (cnt_cur <= 7'd1) begin
          phase_d      = PH_GREEN1;
          tick_count_d = '0;
          running_d    = 1'b0;
        end else begin
          tick_count_d = cnt_cur - 1'b1;
        end
      end
      default: begin
        phase_d = PH_GREEN1;
      end
    endcase
  end

  // outputs of the tick
  always_comb begin
    road = first_road_d;
    lamp = LightGreen;
    seg  = seg_of_digit(mod10(cnt_cur));
    unique case (ph_cur)
      PH_GREEN1: begin
        road = first_road_d;
      end
      PH_YELLOW1: begin
        lamp = LightYellow;
        seg  = seg_of_digit(4'd0);
      end
      PH_GREEN2: begin
        road = !first_road_d;
      end
      PH_YELLOW2: begin
        road = !first_road_d;
        lamp = LightYellow;
        seg  = seg_of_digit(4'd0);
      end
      default: begin
        road = first_road_d;
      end
    endcase
    out_data_d = {2'b00, road, prio_d, seg,
                  (road == RoadB) ? lamp : LightRed,
                  (road == RoadA) ? lamp : LightRed};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_green_q   <= LongGreenRst;
      short_green_q  <= ShortGreenRst;
      yellow_ticks_q <= YellowTicksRst;
      equal_band_q   <= EqualBandRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LONG_GREEN:   long_green_q   <= cfg_data_i[GreenW-1:0];
        CFG_SHORT_GREEN:  short_green_q  <= cfg_data_i[GreenW-1:0];
        CFG_YELLOW_TICKS: yellow_ticks_q <= cfg_data_i[YellowW-1:0];
        CFG_EQUAL_BAND:   equal_band_q   <= cfg_data_i[BandW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_GREEN1;
      tick_count_q   <= '0;
      first_road_q   <= RoadA;
      second_green_q <= '0;
      prio_q         <= PrioEqual;
      running_q      <= 1'b0;
    end else if (accept) begin
      phase_q        <= phase_d;
      tick_count_q   <= tick_count_d;
      first_road_q   <= first_road_d;
      second_green_q <= second_green_d;
      prio_q         <= prio_d;
      running_q      <= running_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/trtl_checker.sv =====
// ---------------------------------------------------------------------------
// trtl_checker
// port level checks of the two road traffic light unit, bound to the top
// ---------------------------------------------------------------------------
`include "two_road_priority_traffic_light_unit_macros.svh"

module trtl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [trtl_pkg::OutW-1:0]    m_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);
  import trtl_pkg::*;

  logic [1:0] la, lb;
  logic       go;
  logic       in_acc;
  logic       out_stall;
  logic       lamps_ok;

  assign la        = m_axis_tdata[1:0];
  assign lb        = m_axis_tdata[3:2];
  assign go        = m_axis_tdata[13];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign lamps_ok  = (go == RoadA) ? (lb == LightRed && la != LightRed)
                                   : (la == LightRed && lb != LightRed);

  // held result stays put while stalled
  `TRTL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // only the road going shows a lamp other than red
  `TRTL_ASSERT_NOW(a_one_road, clk_i, rst_ni, m_axis_tvalid, lamps_ok)

  // input stalls only behind a stalled result
  `TRTL_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready, out_stall)

  // every accepted tick leaves a result
  `TRTL_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, m_axis_tvalid)

endmodule

bind two_road_priority_traffic_light_unit trtl_checker u_trtl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
